>>> hw/rtl/qbvs_pkg.sv
// Package for the quad batch vertex setup block.
// Holds limits, field widths, command codes and shared types; no dependencies.
package qbvs_pkg;

   localparam int unsigned QUAD_MAX  = 4096;
   localparam int unsigned SLOT_MAX  = 32;
   localparam int unsigned QCNT_W    = $clog2(QUAD_MAX + 1);
   localparam int unsigned SCNT_W    = $clog2(SLOT_MAX + 1);
   localparam int unsigned SLOT_W    = $clog2(SLOT_MAX);
   localparam int unsigned TEX_W     = 16;
   localparam int unsigned POS_W     = 32;
   localparam int unsigned TRIG_W    = 16;
   localparam int unsigned PROD_W    = POS_W + TRIG_W;
   localparam logic [15:0] TIL_WHITE = 16'd256;

   typedef enum logic [1:0] {
      CMD_DRAW  = 2'd0,
      CMD_BEGIN = 2'd1,
      CMD_END   = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   localparam logic KIND_VERTEX = 1'b0;
   localparam logic KIND_FLUSH  = 1'b1;

   typedef struct packed {
      logic signed [TRIG_W-1:0] trig;
      logic signed [POS_W-1:0]  size;
   } mul_req_type;

endpackage

>>> hw/rtl/qbvs_intf.sv
// Valid/ready channel interfaces for command and vertex transactions.
// Depends on qbvs_pkg.
interface qbvs_req_if import qbvs_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [1:0]        cmd;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [31:0] pos_z;
   logic signed [31:0] size_x;
   logic signed [31:0] size_y;
   logic signed [15:0] cos_val;
   logic signed [15:0] sin_val;
   logic [31:0]       tint;
   logic [15:0]       tex_id;
   logic [15:0]       tiling;
   modport source (output valid, cmd, pos_x, pos_y, pos_z, size_x, size_y, cos_val,
                   sin_val, tint, tex_id, tiling, input ready);
   modport sink (input valid, cmd, pos_x, pos_y, pos_z, size_x, size_y, cos_val,
                 sin_val, tint, tex_id, tiling, output ready);
endinterface

interface qbvs_rsp_if import qbvs_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              kind;
   logic signed [31:0] vx;
   logic signed [31:0] vy;
   logic signed [31:0] vz;
   logic              tex_u;
   logic              tex_v;
   logic [31:0]       vcolor;
   logic [4:0]        slot;
   logic [15:0]       vtiling;
   logic [12:0]       batch_quads;
   logic [5:0]        slots_used;
   logic              last;
   modport source (output valid, kind, vx, vy, vz, tex_u, tex_v, vcolor, slot, vtiling,
                   batch_quads, slots_used, last, input ready);
   modport sink (input valid, kind, vx, vy, vz, tex_u, tex_v, vcolor, slot, vtiling,
                 batch_quads, slots_used, last, output ready);
endinterface

>>> hw/rtl/qbvs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module qbvs_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

>>> hw/rtl/qbvs_mul.sv
// Shared signed trig-by-size multiplier with registered product.
// Depends on qbvs_pkg.
module qbvs_mul import qbvs_pkg::*; (
   input  logic                     clock,
   input  mul_req_type              req,
   output logic signed [PROD_W-1:0] prod
);
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;

   assign prod_in = PROD_W'(req.trig) * PROD_W'(req.size);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;
endmodule

>>> hw/rtl/quad_batch_vertex_setup.sv
// Quad batch vertex setup: one sprite command per transaction in, vertex and
// flush records out. An untextured draw skips the slot table. A textured draw
// walks the slot table, comparing up to 31 entries, and adds an entry when the
// texture is new. The walk reads the slot table one entry at a time, and the
// one shared multiplier does four products. A draw yields up to five records,
// and it stalls while the result register waits on rsp ready.
// Begin resets the batch; end emits a flush record unless the batch is empty.
// No clearing pass after reset.
// Depends on qbvs_pkg, qbvs_intf, qbvs_ram, qbvs_mul.
module quad_batch_vertex_setup import qbvs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   qbvs_req_if.sink    req_if,
   qbvs_rsp_if.source  rsp_if
);
   typedef enum logic [7:0] {
      ST_IDLE = 8'b0000_0001,
      ST_QCHK = 8'b0000_0010,
      ST_SRD  = 8'b0000_0100,
      ST_SCMP = 8'b0000_1000,
      ST_SNEW = 8'b0001_0000,
      ST_MUL  = 8'b0010_0000,
      ST_VERT = 8'b0100_0000,
      ST_END  = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic [QCNT_W-1:0] quad_ff, quad_in;
   logic [SCNT_W-1:0] scnt_ff, scnt_in;
   logic [SCNT_W-1:0] idx_ff, idx_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [2:0]        step_ff, step_in;
   logic [1:0]        corner_ff, corner_in;

   logic signed [31:0] px_ff, py_ff, pz_ff, sx_ff, sy_ff;
   logic signed [15:0] c_ff, s_ff;
   logic [31:0]        tint_ff;
   logic [15:0]        tex_ff, til_ff, til_in;
   logic signed [PROD_W-1:0] pa_ff, pb_ff, pc_ff, pd_ff;

   logic        ov_ff, ov_in;
   logic        okind_ff, okind_in, olast_ff, olast_in, ou_ff, ou_in, ov2_ff, ov2_in;
   logic [31:0] ox_ff, ox_in, oy_ff, oy_in, oz_ff, oz_in, ocol_ff, ocol_in;
   logic [4:0]  oslot_ff, oslot_in;
   logic [15:0] otil_ff, otil_in;
   logic [12:0] obq_ff, obq_in;
   logic [5:0]  osu_ff, osu_in;

   logic out_free, accept, load_flush, load_vtx;
   logic ram_we;
   logic [SLOT_W-1:0] ram_waddr;
   logic [TEX_W-1:0]  ram_rdata;
   mul_req_type       mreq;
   logic signed [PROD_W-1:0] prod;
   logic signed [PROD_W+1:0] sumx, sumy;
   logic signed [PROD_W+1:0] ea, eb, ec, ed;
   logic                     pos_ex, pos_ey;
   logic        sfull, sneed;

   assign out_free = !ov_ff || rsp_if.ready;
   assign req_if.ready = (state_ff == ST_IDLE);
   assign accept = req_if.valid && req_if.ready;

   qbvs_ram #(.WIDTH(TEX_W), .DEPTH(SLOT_MAX)) u_slot_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (tex_ff),
      .raddr (idx_ff[SLOT_W-1:0]),
      .rdata (ram_rdata)
   );

   always_comb begin
      unique case (step_ff[1:0])
         2'd0: mreq = '{trig: c_ff, size: sx_ff};
         2'd1: mreq = '{trig: s_ff, size: sy_ff};
         2'd2: mreq = '{trig: s_ff, size: sx_ff};
         default: mreq = '{trig: c_ff, size: sy_ff};
      endcase
   end

   qbvs_mul u_mul (.clock(clock), .req(mreq), .prod(prod));

   assign pos_ex = (corner_ff == 2'd1) || (corner_ff == 2'd2);
   assign pos_ey = corner_ff[1];
   assign ea = (PROD_W+2)'(pa_ff);
   assign eb = (PROD_W+2)'(pb_ff);
   assign ec = (PROD_W+2)'(pc_ff);
   assign ed = (PROD_W+2)'(pd_ff);
   assign sumx = (pos_ex ? ea : -ea) + (pos_ey ? -eb : eb) + (PROD_W+2)'(16384);
   assign sumy = (pos_ex ? ec : -ec) + (pos_ey ? ed : -ed) + (PROD_W+2)'(16384);

   assign sfull = (scnt_ff >= SCNT_W'(SLOT_MAX));
   assign sneed = sfull && (quad_ff != '0);

   always_comb begin
      state_in  = state_ff;
      quad_in   = quad_ff;
      scnt_in   = scnt_ff;
      idx_in    = idx_ff;
      slot_in   = slot_ff;
      step_in   = step_ff;
      corner_in = corner_ff;
      til_in    = til_ff;
      ram_we    = 1'b0;
      ram_waddr = scnt_ff[SLOT_W-1:0];
      load_flush = 1'b0;
      load_vtx   = 1'b0;
      olast_in   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               til_in = req_if.tiling;
               unique case (cmd_type'(req_if.cmd))
                  CMD_DRAW: state_in = ST_QCHK;
                  CMD_BEGIN: begin
                     quad_in = '0;
                     scnt_in = SCNT_W'(1);
                  end
                  CMD_END: begin
                     if (quad_ff != '0) state_in = ST_END;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_END: begin
            if (out_free) begin
               load_flush = 1'b1;
               olast_in   = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_QCHK: begin
            if (quad_ff >= QCNT_W'(QUAD_MAX)) begin
               if (out_free) begin
                  load_flush = 1'b1;
                  quad_in    = '0;
                  scnt_in    = SCNT_W'(1);
                  state_in   = ST_SRD;
               end
            end else begin
               state_in = ST_SRD;
            end
            idx_in = SCNT_W'(1);
         end
         ST_SRD: begin
            if (tex_ff == '0) begin
               slot_in  = '0;
               til_in   = TIL_WHITE;
               step_in  = '0;
               state_in = ST_MUL;
            end else if (idx_ff < scnt_ff) begin
               state_in = ST_SCMP;
            end else begin
               state_in = ST_SNEW;
            end
         end
         ST_SCMP: begin
            if (ram_rdata == tex_ff) begin
               slot_in  = idx_ff[SLOT_W-1:0];
               step_in  = '0;
               state_in = ST_MUL;
            end else begin
               idx_in   = idx_ff + SCNT_W'(1);
               state_in = ST_SRD;
            end
         end
         ST_SNEW: begin
            if (!sneed || out_free) begin
               load_flush = sneed;
               ram_we     = 1'b1;
               ram_waddr  = sfull ? SLOT_W'(1) : scnt_ff[SLOT_W-1:0];
               slot_in    = ram_waddr;
               scnt_in    = sfull ? SCNT_W'(2) : scnt_ff + SCNT_W'(1);
               if (sfull) quad_in = '0;
               step_in    = '0;
               state_in   = ST_MUL;
            end
         end
         ST_MUL: begin
            step_in = step_ff + 3'd1;
            if (step_ff == 3'd4) begin
               corner_in = '0;
               state_in  = ST_VERT;
            end
         end
         ST_VERT: begin
            if (out_free) begin
               load_vtx  = 1'b1;
               corner_in = corner_ff + 2'd1;
               if (corner_ff == 2'd3) begin
                  olast_in = 1'b1;
                  quad_in  = quad_ff + QCNT_W'(1);
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ov_in    = ov_ff && !rsp_if.ready;
      okind_in = okind_ff;
      ox_in = ox_ff; oy_in = oy_ff; oz_in = oz_ff; ocol_in = ocol_ff;
      ou_in = ou_ff; ov2_in = ov2_ff; oslot_in = oslot_ff; otil_in = otil_ff;
      obq_in = obq_ff; osu_in = osu_ff;
      if (load_flush) begin
         ov_in = 1'b1; okind_in = KIND_FLUSH;
         ox_in = '0; oy_in = '0; oz_in = '0; ocol_in = '0; ou_in = 1'b0; ov2_in = 1'b0;
         oslot_in = '0; otil_in = '0;
         obq_in = 13'(quad_ff);
         osu_in = 6'(scnt_ff);
      end else if (load_vtx) begin
         ov_in = 1'b1; okind_in = KIND_VERTEX;
         ox_in = px_ff + sumx[46:15];
         oy_in = py_ff + sumy[46:15];
         oz_in = pz_ff; ocol_in = tint_ff; ou_in = pos_ex; ov2_in = pos_ey;
         oslot_in = 5'(slot_ff); otil_in = til_ff; obq_in = '0; osu_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         quad_ff  <= '0;
         scnt_ff  <= SCNT_W'(1);
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         quad_ff  <= quad_in;
         scnt_ff  <= scnt_in;
         ov_ff    <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in; slot_ff <= slot_in; step_ff <= step_in; corner_ff <= corner_in;
      til_ff <= til_in;
      if (accept) begin
         px_ff <= req_if.pos_x; py_ff <= req_if.pos_y; pz_ff <= req_if.pos_z;
         sx_ff <= req_if.size_x; sy_ff <= req_if.size_y;
         c_ff <= req_if.cos_val; s_ff <= req_if.sin_val;
         tint_ff <= req_if.tint; tex_ff <= req_if.tex_id;
      end
      if (state_ff == ST_MUL) begin
         unique case (step_ff)
            3'd1: pa_ff <= prod;
            3'd2: pb_ff <= prod;
            3'd3: pc_ff <= prod;
            3'd4: pd_ff <= prod;
            default: ;
         endcase
      end
      if (load_flush || load_vtx) olast_ff <= olast_in;
      okind_ff <= okind_in; ox_ff <= ox_in; oy_ff <= oy_in; oz_ff <= oz_in;
      ocol_ff <= ocol_in; ou_ff <= ou_in; ov2_ff <= ov2_in; oslot_ff <= oslot_in;
      otil_ff <= otil_in; obq_ff <= obq_in; osu_ff <= osu_in;
   end

   assign rsp_if.valid       = ov_ff;
   assign rsp_if.kind        = okind_ff;
   assign rsp_if.vx          = ox_ff;
   assign rsp_if.vy          = oy_ff;
   assign rsp_if.vz          = oz_ff;
   assign rsp_if.tex_u       = ou_ff;
   assign rsp_if.tex_v       = ov2_ff;
   assign rsp_if.vcolor      = ocol_ff;
   assign rsp_if.slot        = oslot_ff;
   assign rsp_if.vtiling     = otil_ff;
   assign rsp_if.batch_quads = obq_ff;
   assign rsp_if.slots_used  = osu_ff;
   assign rsp_if.last        = olast_ff;

   a_scnt_range: assert property (@(posedge clock) disable iff (reset)
      scnt_ff >= SCNT_W'(1) && scnt_ff <= SCNT_W'(SLOT_MAX))
      else $error("slot count out of range");
   a_quad_range: assert property (@(posedge clock) disable iff (reset)
      quad_ff <= QCNT_W'(QUAD_MAX))
      else $error("quad count out of range");
   a_flush_nonempty: assert property (@(posedge clock) disable iff (reset)
      load_flush |-> quad_ff != '0)
      else $error("flush of empty batch");
   a_vtx_slot: assert property (@(posedge clock) disable iff (reset)
      load_vtx |-> SCNT_W'(slot_ff) < scnt_ff)
      else $error("vertex slot not bound");
endmodule
